// ===== rtl/core/htfd_pkg.sv =====
`default_nettype none

package htfd_pkg;

   // characters of the frame syntax
   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_A       = 8'h41;
   localparam logic [7:0] CHAR_NINE    = 8'd57;
   localparam logic [7:0] ZERO_OFFSET  = 8'd48;
   localparam logic [7:0] ALPHA_OFFSET = 8'd55;

   // packet kinds
   localparam logic [7:0] KIND_SATS = 8'd0;
   localparam logic [7:0] KIND_ALT  = 8'd1;
   localparam logic [7:0] KIND_LON  = 8'd2;
   localparam logic [7:0] KIND_LAT  = 8'd3;

   localparam logic [7:0] MIN_SATS_RESET = 8'd5;

   // index of the last hex character of a frame
   localparam logic [2:0] HEX_LAST = 3'd7;

   // floor(x / 3) == (x * RECIP_THIRD) >> RECIP_SHIFT for any 32-bit x
   localparam logic [31:0] RECIP_THIRD = 32'hAAAA_AAAB;
   localparam int          RECIP_SHIFT = 33;

   // saturation bounds of the converted magnitude
   localparam logic [32:0] POS_LIMIT = 33'h0_7FFF_FFFF;
   localparam logic [32:0] NEG_LIMIT = 33'h0_8000_0000;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_KIND,
      PH_HEX
   } phase_type;

   // completed frame, with the magnitude of the signed word
   typedef struct packed {
      logic [7:0]  kind;
      logic [31:0] word;
      logic        neg;
      logic [31:0] mag;
   } frame_type;

   // frame with the unsaturated converted magnitude
   typedef struct packed {
      logic [7:0]  kind;
      logic [31:0] word;
      logic        neg;
      logic [32:0] quot;
   } coord_type;

   // hex value of one character, mod 256
   function automatic logic [7:0] digit_value(input logic [7:0] c);
      digit_value = (c <= CHAR_NINE) ? c - ZERO_OFFSET : c - ALPHA_OFFSET;
   endfunction

   // round-away correction for (5*r + 1) / 3 with r = 3a + rem
   function automatic logic [1:0] rem_bonus(input logic [1:0] rem);
      case (rem)
         2'd1:    rem_bonus = 2'd2;
         2'd2:    rem_bonus = 2'd3;
         default: rem_bonus = 2'd0;
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hex_telemetry_frame_decoder.sv =====
`default_nettype none

// Telemetry frame decoder. Takes one ASCII character per request, every cycle while
// req_stall is low: a frame is '$', a kind letter, then eight hex characters (first
// pair most significant). Each completed frame updates the telemetry registers
// (satellite count, altitude, longitude or latitude scaled by 100/60 with round half
// away from zero and saturation, sticky altitude and fix flags) and produces one
// response carrying the kind and all current values. A character is accepted each
// cycle the frame slot is free; a frame travels four register stages (frame slot,
// reciprocal multiply, quotient, telemetry/response register) before its response
// is valid. While a response waits, characters keep being taken until the frame
// slot and the two coordinate stages behind it hold frames; then req_stall holds
// the input. The user must write the fix threshold register through csr_ only
// while idle; the block itself does not enforce it.
module hex_telemetry_frame_decoder
   import htfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_char,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_frame_kind,
   output logic [7:0]       rsp_sat_count,
   output logic signed [15:0] rsp_altitude,
   output logic signed [31:0] rsp_longitude,
   output logic signed [31:0] rsp_latitude,
   output logic             rsp_altitude_seen,
   output logic             rsp_fix_seen,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_min_sats_for_fix
);

   logic        frame_valid;
   frame_type   frame;
   logic        frame_free;
   logic        c_valid;
   coord_type   c_data;
   logic        out_free;
   logic        load;
   logic [31:0] conv;
   logic [31:0] neg_mag;

   logic [7:0]  min_sats_ff;
   logic        rsp_valid_ff;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  sats_ff, sats_in;
   logic [15:0] alt_ff, alt_in;
   logic [31:0] lon_ff, lon_in;
   logic [31:0] lat_ff, lat_in;
   logic        alt_flag_ff, alt_flag_in;
   logic        fix_flag_ff, fix_flag_in;

   htfd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_char (req_rx_char),
      .frame_valid (frame_valid),
      .frame       (frame),
      .frame_free  (frame_free)
   );

   htfd_coord u_coord (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (frame_valid),
      .in_data   (frame),
      .in_free   (frame_free),
      .out_valid (c_valid),
      .out_data  (c_data),
      .out_free  (out_free)
   );

   // fix threshold register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_sats_ff <= MIN_SATS_RESET;
      end else if (csr_valid && csr_ready) begin
         min_sats_ff <= csr_min_sats_for_fix;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = c_valid && out_free;

   // saturate and apply the sign of the converted coordinate
   always_comb begin
      neg_mag = (c_data.quot > NEG_LIMIT) ? NEG_LIMIT[31:0] : c_data.quot[31:0];
      if (c_data.neg) begin
         conv = 32'd0 - neg_mag;
      end else begin
         conv = (c_data.quot > POS_LIMIT) ? POS_LIMIT[31:0] : c_data.quot[31:0];
      end
   end

   // apply the frame to the telemetry registers
   always_comb begin
      kind_in     = kind_ff;
      sats_in     = sats_ff;
      alt_in      = alt_ff;
      lon_in      = lon_ff;
      lat_in      = lat_ff;
      alt_flag_in = alt_flag_ff;
      fix_flag_in = fix_flag_ff;
      if (load) begin
         kind_in = c_data.kind;
         case (c_data.kind)
            KIND_SATS: begin
               sats_in = c_data.word[31:24];
            end
            KIND_ALT: begin
               alt_in      = c_data.word[23:8];
               alt_flag_in = 1'b1;
            end
            KIND_LON: begin
               lon_in = conv;
            end
            KIND_LAT: begin
               lat_in = conv;
               if (sats_ff >= min_sats_ff) begin
                  fix_flag_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         kind_ff      <= '0;
         sats_ff      <= '0;
         alt_ff       <= '0;
         lon_ff       <= '0;
         lat_ff       <= '0;
         alt_flag_ff  <= 1'b0;
         fix_flag_ff  <= 1'b0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= c_valid;
         end
         kind_ff     <= kind_in;
         sats_ff     <= sats_in;
         alt_ff      <= alt_in;
         lon_ff      <= lon_in;
         lat_ff      <= lat_in;
         alt_flag_ff <= alt_flag_in;
         fix_flag_ff <= fix_flag_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_kind    = kind_ff;
   assign rsp_sat_count     = sats_ff;
   assign rsp_altitude      = alt_ff;
   assign rsp_longitude     = lon_ff;
   assign rsp_latitude      = lat_ff;
   assign rsp_altitude_seen = alt_flag_ff;
   assign rsp_fix_seen      = fix_flag_ff;

endmodule

`default_nettype wire

// ===== rtl/core/htfd_parser.sv =====
`default_nettype none

module htfd_parser
   import htfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_char,
   output logic            frame_valid,
   output frame_type       frame,
   input  wire logic       frame_free
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  count_ff, count_in;
   logic [31:0] word_ff, word_in;
   logic [7:0]  kind_ff, kind_in;
   logic        fvalid_ff, fvalid_in;
   frame_type   frame_ff, frame_in;
   logic        slot_free;
   logic        accept;
   logic        complete;
   logic [7:0]  digit;

   // the frame slot takes a new frame when empty or moving on
   assign slot_free = !fvalid_ff || frame_free;
   assign req_stall = !slot_free;
   assign accept    = req_valid && slot_free;
   assign digit     = digit_value(req_rx_char);

   // parse state machine
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      word_in  = word_ff;
      kind_in  = kind_ff;
      complete = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_KIND: begin
               kind_in  = req_rx_char - CHAR_A;
               count_in = '0;
               phase_in = PH_HEX;
            end
            PH_HEX: begin
               if (!count_ff[0]) begin
                  word_in = {word_ff[23:0], digit[3:0], 4'b0000};
               end else begin
                  word_in = {word_ff[31:8], word_ff[7:0] + digit};
               end
               count_in = count_ff + 3'd1;
               if (count_ff == HEX_LAST) begin
                  complete = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = (req_rx_char == CHAR_DOLLAR) ? PH_KIND : PH_IDLE;
               count_in = '0;
            end
         endcase
      end
   end

   // frame slot
   always_comb begin
      frame_in  = frame_ff;
      fvalid_in = fvalid_ff;
      if (complete) begin
         frame_in.kind = kind_ff;
         frame_in.word = word_in;
         frame_in.neg  = word_in[31];
         frame_in.mag  = word_in[31] ? 32'd0 - word_in : word_in;
         fvalid_in     = 1'b1;
      end else if (frame_free) begin
         fvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         count_ff  <= '0;
         word_ff   <= '0;
         kind_ff   <= '0;
         fvalid_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         word_ff   <= word_in;
         kind_ff   <= kind_in;
         fvalid_ff <= fvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign frame_valid = fvalid_ff;
   assign frame       = frame_ff;

endmodule

`default_nettype wire

// ===== rtl/core/htfd_coord.sv =====
`default_nettype none

module htfd_coord
   import htfd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   input  wire frame_type in_data,
   output logic           in_free,
   output logic           out_valid,
   output coord_type      out_data,
   input  wire logic      out_free
);

   logic        m_valid_ff;
   frame_type   m_frame_ff;
   logic [30:0] m_third_ff;
   logic [63:0] product;
   logic        m_free;

   logic        q_valid_ff;
   coord_type   q_data_ff, q_data_in;
   logic        q_free;
   logic [32:0] three_a;
   logic [32:0] five_a;
   logic [31:0] rem_full;

   assign q_free  = !q_valid_ff || out_free;
   assign m_free  = !m_valid_ff || q_free;
   assign in_free = m_free;

   // reciprocal multiply: magnitude / 3
   assign product = in_data.mag * RECIP_THIRD;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (m_free) begin
         m_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (m_free) begin
         m_frame_ff <= in_data;
         m_third_ff <= product[63:RECIP_SHIFT];
      end
   end

   // quotient of (5*mag + 1) / 3 from mag = 3a + rem
   always_comb begin
      three_a  = {1'b0, m_third_ff, 1'b0} + {2'b00, m_third_ff};
      five_a   = {m_third_ff, 2'b00} + {2'b00, m_third_ff};
      rem_full = m_frame_ff.mag - three_a[31:0];
      q_data_in.kind = m_frame_ff.kind;
      q_data_in.word = m_frame_ff.word;
      q_data_in.neg  = m_frame_ff.neg;
      q_data_in.quot = five_a + {31'd0, rem_bonus(rem_full[1:0])};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else if (q_free) begin
         q_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (q_free) begin
         q_data_ff <= q_data_in;
      end
   end

   assign out_valid = q_valid_ff;
   assign out_data  = q_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/htfd_checker.sv =====
`default_nettype none

module htfd_checker
   import htfd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_frame_kind,
   input wire logic [7:0]  rsp_sat_count,
   input wire logic [31:0] rsp_latitude,
   input wire logic        rsp_altitude_seen,
   input wire logic        rsp_fix_seen
);

   // a stalled response stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_kind)
         && $stable(rsp_sat_count) && $stable(rsp_latitude))
      else $error("stalled response changed");

   // sticky flags never drop
   assert property (@(posedge clock) disable iff (reset)
      rsp_altitude_seen |=> rsp_altitude_seen)
      else $error("altitude flag cleared");

   assert property (@(posedge clock) disable iff (reset)
      rsp_fix_seen |=> rsp_fix_seen)
      else $error("fix flag cleared");

   // an altitude response always shows the altitude flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_kind == KIND_ALT |-> rsp_altitude_seen)
      else $error("altitude response without altitude flag");

endmodule

bind hex_telemetry_frame_decoder htfd_checker u_htfd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_frame_kind    (rsp_frame_kind),
   .rsp_sat_count     (rsp_sat_count),
   .rsp_latitude      (rsp_latitude),
   .rsp_altitude_seen (rsp_altitude_seen),
   .rsp_fix_seen      (rsp_fix_seen)
);

`default_nettype wire
